// ===== design/cttess_pkg.sv =====
// Shared types, constants and the trig function for the circle tessellator.
// No dependencies; every other design file imports this package.
package cttess_pkg;

   localparam int CTT_SEGMENTS   = 16;
   localparam int CTT_FIFO_DEPTH = 2;
   localparam logic [63:0] CTT_PIH_Q30 = 64'd1686629713;

   typedef enum logic {
      CTT_MODE_DISK = 1'b0,
      CTT_MODE_RING = 1'b1
   } ctt_mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FILL,
      ST_EMIT_A,
      ST_EMIT_B
   } ctt_state_type;

   typedef struct packed {
      logic               req_type;
      logic signed [15:0] center_x;
      logic signed [15:0] center_y;
      logic [14:0]        radius;
      logic [14:0]        thickness;
      logic [31:0]        color;
   } ctt_req_type;

   typedef struct packed {
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [15:0] bx;
      logic signed [15:0] by;
      logic signed [15:0] vx;
      logic signed [15:0] vy;
      logic [31:0]        tri_color;
      logic               last;
   } ctt_rsp_type;

   // classified request: radii in unsigned Q16.1
   typedef struct packed {
      ctt_mode_type       mode;
      logic signed [15:0] cx;
      logic signed [15:0] cy;
      logic [16:0]        r_outer;
      logic [16:0]        r_inner;
      logic [31:0]        color;
   } ctt_job_type;

   typedef struct packed {
      logic signed [34:0] ox;
      logic signed [34:0] oy;
      logic signed [34:0] ix;
      logic signed [34:0] iy;
   } ctt_prod_type;

   typedef struct packed {
      logic signed [15:0] ox;
      logic signed [15:0] oy;
      logic signed [15:0] ix;
      logic signed [15:0] iy;
   } ctt_point_type;

   // first-quadrant sine, q in 0..2^30, result Q1.15 in 0..32768
   function automatic logic signed [16:0] cttess_quad_sine(input logic [63:0] q);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      longint      sum;
      longint      r;
      x   = (q * CTT_PIH_Q30) >> 30;
      x2  = (x * x) >> 30;
      t   = x;
      sum = longint'(x);
      t   = ((t * x2) >> 30) / 64'd6;
      sum = sum - longint'(t);
      t   = ((t * x2) >> 30) / 64'd20;
      sum = sum + longint'(t);
      t   = ((t * x2) >> 30) / 64'd42;
      sum = sum - longint'(t);
      t   = ((t * x2) >> 30) / 64'd72;
      sum = sum + longint'(t);
      t   = ((t * x2) >> 30) / 64'd110;
      sum = sum - longint'(t);
      if (sum < 0) sum = 0;
      r = (sum + 64'sd16384) >>> 15;
      if (r > 32768) r = 32768;
      return 17'(r);
   endfunction

   // sine of a 32-bit phase (full turn = 2^32), Q1.15
   function automatic logic signed [16:0] cttess_phase_sine(input logic [31:0] p);
      logic [63:0]        q;
      logic signed [16:0] s;
      q = {34'd0, p[29:0]};
      if (p[30]) begin
         s = cttess_quad_sine(64'd1073741824 - q);
      end else begin
         s = cttess_quad_sine(q);
      end
      return p[31] ? -s : s;
   endfunction

endpackage

// ===== design/circle_triangle_tessellator_top.sv =====
// Circle tessellator: turns one circle request into fan or ring triangles.
//
// Request channel: a word on req_item is taken at a rising edge with start
// high and busy low. busy is high while the two-entry job queue is full.
// Result channel: each triangle sits on rsp_item for exactly one cycle,
// marked by rsp_strobe; rsp_item.last flags the final triangle of a circle.
// The receiver cannot stall; triangles leave as soon as they are built.
// The back end sets the pace: it builds one rim point pair per segment
// through its multiply pipeline and sends one triangle per cycle, giving
// SEGMENTS triangles for a disk and 2*SEGMENTS for a ring. The front end
// classifies and queues the next requests meanwhile.
// Reset (synchronous, active high) empties the queue and idles the back
// end; any circle in flight is dropped.
// Depends on cttess_pkg, cttess_front, cttess_fifo, cttess_back.
module circle_triangle_tessellator_top
   import cttess_pkg::*;
#(
   parameter int SEGMENTS = CTT_SEGMENTS
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  ctt_req_type req_item,
   output logic        rsp_strobe,
   output ctt_rsp_type rsp_item
);

   logic        q_push;
   logic        q_pop;
   logic        q_full;
   logic        q_not_empty;
   ctt_job_type push_job;
   ctt_job_type head_job;

   cttess_front u_front (
      .start    (start),
      .req_item (req_item),
      .q_full   (q_full),
      .busy     (busy),
      .q_push   (q_push),
      .q_job    (push_job)
   );

   cttess_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (push_job),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_job  (head_job)
   );

   cttess_back #(
      .SEGMENTS (SEGMENTS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (q_not_empty),
      .job        (head_job),
      .job_pop    (q_pop),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

// ===== design/cttess_front.sv =====
// Front end: takes requests, works out the ring radii and pushes jobs.
// Depends on cttess_pkg.
module cttess_front
   import cttess_pkg::*;
(
   input  logic        start,
   input  ctt_req_type req_item,
   input  logic        q_full,
   output logic        busy,
   output logic        q_push,
   output ctt_job_type q_job
);

   logic [15:0] dbl;
   logic [16:0] sum;

   always_comb begin
      dbl    = {req_item.radius, 1'b0};
      sum    = {1'b0, dbl} + {2'b00, req_item.thickness};
      busy   = q_full;
      q_push = start && !q_full;

      q_job.cx    = req_item.center_x;
      q_job.cy    = req_item.center_y;
      q_job.color = req_item.color;
      if (req_item.req_type == CTT_MODE_RING) begin
         q_job.mode    = CTT_MODE_RING;
         q_job.r_outer = sum;
         // inner radius clamps at zero
         q_job.r_inner = (dbl > {1'b0, req_item.thickness}) ?
                         {1'b0, dbl - {1'b0, req_item.thickness}} : 17'd0;
      end else begin
         q_job.mode    = CTT_MODE_DISK;
         q_job.r_outer = {1'b0, dbl};
         q_job.r_inner = 17'd0;
      end
   end

endmodule

// ===== design/cttess_fifo.sv =====
// Short job queue between front and back end.
// Depends on cttess_pkg.
module cttess_fifo
   import cttess_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  ctt_job_type push_job,
   input  logic        pop,
   output logic        full,
   output logic        not_empty,
   output ctt_job_type head_job
);

   localparam int PTR_W = (CTT_FIFO_DEPTH > 1) ? $clog2(CTT_FIFO_DEPTH) : 1;
   localparam int CNT_W = $clog2(CTT_FIFO_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CTT_FIFO_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CTT_FIFO_DEPTH);

   ctt_job_type      slot_ff [CTT_FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      full      = (count_ff == CNT_FULL);
      not_empty = (count_ff != '0);
      head_job  = slot_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      count_ff == CNT_FULL |-> !push)
      else $error("job pushed into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> !pop)
      else $error("job popped from an empty queue");

endmodule

// ===== design/cttess_back.sv =====
// Back end: walks the segments of one job and emits its triangles.
// Depends on cttess_pkg (types, sine function).
module cttess_back
   import cttess_pkg::*;
#(
   parameter int SEGMENTS = CTT_SEGMENTS
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        job_valid,
   input  ctt_job_type job,
   output logic        job_pop,
   output logic        rsp_strobe,
   output ctt_rsp_type rsp_item
);

   localparam int SEG_W = $clog2(SEGMENTS);
   localparam logic [SEG_W-1:0] SEG_LAST = SEG_W'(SEGMENTS - 1);

   logic signed [16:0] cos_tab [SEGMENTS];
   logic signed [16:0] sin_tab [SEGMENTS];

   for (genvar g = 0; g < SEGMENTS; g++) begin : g_trig
      localparam logic [31:0] PHASE = 32'((64'(g) << 32) / SEGMENTS);
      localparam logic signed [16:0] SIN_V = cttess_phase_sine(PHASE);
      localparam logic signed [16:0] COS_V = cttess_phase_sine(PHASE + 32'h4000_0000);
      assign sin_tab[g] = SIN_V;
      assign cos_tab[g] = COS_V;
   end

   // centre + round_half_up(prod / 2^16), saturated to 16 bits
   function automatic logic signed [15:0] place(input logic signed [15:0] c,
                                                input logic signed [34:0] prod);
      logic signed [34:0] w;
      logic signed [18:0] sh;
      logic signed [19:0] s;
      w  = prod + 35'sd32768;
      sh = 19'(w >>> 16);
      s  = {sh[18], sh} + {{4{c[15]}}, c};
      if (s > 20'sd32767) begin
         return 16'sh7fff;
      end else if (s < -20'sd32768) begin
         return 16'sh8000;
      end
      return s[15:0];
   endfunction

   ctt_state_type      state_ff, state_in;
   logic [SEG_W-1:0]   idx_ff, idx_in;
   logic [SEG_W-1:0]   seg_ff, seg_in;
   logic [1:0]         fill_ff, fill_in;
   ctt_mode_type       mode_ff;
   logic signed [15:0] cx_ff, cy_ff;
   logic [16:0]        ro_ff, ri_ff;
   logic [31:0]        color_ff;
   ctt_prod_type       prod_ff, prod_in;
   ctt_point_type      cur_ff, cur_in;
   ctt_point_type      prev_ff;
   logic               strobe_ff, strobe_in;
   ctt_rsp_type        rsp_ff, rsp_in;
   logic               load;
   logic               adv;
   logic signed [16:0] cos_v, sin_v;

   always_comb begin
      cos_v      = cos_tab[idx_ff];
      sin_v      = sin_tab[idx_ff];
      prod_in.ox = $signed({1'b0, ro_ff}) * cos_v;
      prod_in.oy = $signed({1'b0, ro_ff}) * sin_v;
      prod_in.ix = $signed({1'b0, ri_ff}) * cos_v;
      prod_in.iy = $signed({1'b0, ri_ff}) * sin_v;
      cur_in.ox  = place(cx_ff, prod_ff.ox);
      cur_in.oy  = place(cy_ff, prod_ff.oy);
      cur_in.ix  = place(cx_ff, prod_ff.ix);
      cur_in.iy  = place(cy_ff, prod_ff.iy);
   end

   always_comb begin
      state_in  = state_ff;
      seg_in    = seg_ff;
      fill_in   = fill_ff;
      idx_in    = idx_ff;
      load      = 1'b0;
      adv       = 1'b0;
      job_pop   = 1'b0;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      rsp_in.tri_color = color_ff;

      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               load     = 1'b1;
               seg_in   = '0;
               fill_in  = '0;
               idx_in   = '0;
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            // prime products, current point and previous point
            adv     = 1'b1;
            fill_in = fill_ff + 1'b1;
            if (fill_ff == 2'd2) begin
               state_in = ST_EMIT_A;
            end
         end
         ST_EMIT_A: begin
            strobe_in = 1'b1;
            if (mode_ff == CTT_MODE_DISK) begin
               rsp_in.ax   = cx_ff;
               rsp_in.ay   = cy_ff;
               rsp_in.bx   = prev_ff.ox;
               rsp_in.by   = prev_ff.oy;
               rsp_in.vx   = cur_ff.ox;
               rsp_in.vy   = cur_ff.oy;
               rsp_in.last = (seg_ff == SEG_LAST);
               adv         = 1'b1;
               if (seg_ff == SEG_LAST) begin
                  state_in = ST_IDLE;
               end else begin
                  seg_in = seg_ff + 1'b1;
               end
            end else begin
               rsp_in.ax   = prev_ff.ox;
               rsp_in.ay   = prev_ff.oy;
               rsp_in.bx   = prev_ff.ix;
               rsp_in.by   = prev_ff.iy;
               rsp_in.vx   = cur_ff.ox;
               rsp_in.vy   = cur_ff.oy;
               rsp_in.last = 1'b0;
               state_in    = ST_EMIT_B;
            end
         end
         ST_EMIT_B: begin
            strobe_in   = 1'b1;
            rsp_in.ax   = cur_ff.ox;
            rsp_in.ay   = cur_ff.oy;
            rsp_in.bx   = prev_ff.ix;
            rsp_in.by   = prev_ff.iy;
            rsp_in.vx   = cur_ff.ix;
            rsp_in.vy   = cur_ff.iy;
            rsp_in.last = (seg_ff == SEG_LAST);
            adv         = 1'b1;
            if (seg_ff == SEG_LAST) begin
               state_in = ST_IDLE;
            end else begin
               seg_in   = seg_ff + 1'b1;
               state_in = ST_EMIT_A;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (adv) begin
         idx_in = (idx_ff == SEG_LAST) ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         seg_ff    <= '0;
         fill_ff   <= '0;
         idx_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         seg_ff    <= seg_in;
         fill_ff   <= fill_in;
         idx_ff    <= idx_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         mode_ff  <= job.mode;
         cx_ff    <= job.cx;
         cy_ff    <= job.cy;
         ro_ff    <= job.r_outer;
         ri_ff    <= job.r_inner;
         color_ff <= job.color;
      end
      if (adv) begin
         prod_ff <= prod_in;
         cur_ff  <= cur_in;
         prev_ff <= cur_ff;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

   a_last_ends_job: assert property (@(posedge clock) disable iff (reset)
      strobe_ff && rsp_ff.last |-> state_ff == ST_IDLE)
      else $error("last triangle sent while job still running");

   a_pop_starts_fill: assert property (@(posedge clock) disable iff (reset)
      job_pop |=> state_ff == ST_FILL && fill_ff == 2'd0 && idx_ff == '0)
      else $error("job popped without restarting the point pipeline");

   a_second_only_ring: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT_B |-> mode_ff == CTT_MODE_RING)
      else $error("second triangle emitted for a disk");

   a_disk_strobe_follows: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT_A |=> strobe_ff)
      else $error("triangle issue lost its strobe");

endmodule
